// ===== src/ppdc_pkg.sv =====
// ppdc_pkg: shared constants, opcodes, register indexes and the controller/datapath command type
// used by the polar pi drive controller datapath, controller and top level
package ppdc_pkg;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_LINE = 2'd1;
  localparam logic [1:0] OP_ROT  = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  localparam logic [2:0] REG_DGP = 3'd0;
  localparam logic [2:0] REG_DGI = 3'd1;
  localparam logic [2:0] REG_BGP = 3'd2;
  localparam logic [2:0] REG_BGI = 3'd3;
  localparam logic [2:0] REG_SGP = 3'd4;
  localparam logic [2:0] REG_SGI = 3'd5;
  localparam logic [2:0] REG_ADS = 3'd6;
  localparam logic [2:0] REG_AAN = 3'd7;

  localparam int PiQ     = 25736;
  localparam int HalfPiQ = 12868;
  localparam int TwoPiQ  = 51472;
  localparam int OneQ    = 16384;

  function automatic logic signed [14:0] atan_entry(input logic [3:0] i);
    logic signed [14:0] r;
    unique case (i)
      4'd0: r = 15'sd6434;
      4'd1: r = 15'sd3798;
      4'd2: r = 15'sd2007;
      4'd3: r = 15'sd1019;
      4'd4: r = 15'sd511;
      4'd5: r = 15'sd256;
      4'd6: r = 15'sd128;
      4'd7: r = 15'sd64;
      4'd8: r = 15'sd32;
      4'd9: r = 15'sd16;
      4'd10: r = 15'sd8;
      4'd11: r = 15'sd4;
      4'd12: r = 15'sd2;
      4'd13: r = 15'sd1;
      default: r = 15'sd0;
    endcase
    return r;
  endfunction

  // one step of the datapath sequence, issued by the controller
  typedef struct packed {
    logic load;     // capture item, compute dx dy terr
    logic sqrt_st;  // one isqrt step
    logic cord_st;  // one cordic step
    logic post;     // clamp, fold, sums
    logic mul_st;   // one product term
    logic combine;  // form left and right
    logic div_st;   // one quotient bit
    logic finish;   // write result register
  } ppdc_cmd_t;

  typedef struct packed {
    logic rot;
    logic need_div;
  } ppdc_sts_t;

endpackage

// ===== src/ppdc_datapath.sv =====
// ppdc_datapath: goal state, integrators, isqrt, cordic, shared multiplier and divider
// depends on ppdc_pkg; sequenced by ppdc_ctrl
module ppdc_datapath
  import ppdc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ppdc_cmd_t          cmd_i,
  input  logic [2:0]         step_i,
  output ppdc_sts_t          sts_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] heading_i,
  input  logic signed [15:0] goal_x_i,
  input  logic signed [15:0] goal_y_i,
  input  logic signed [15:0] goal_heading_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  output logic signed [15:0] left_cmd_o,
  output logic signed [15:0] right_cmd_o,
  output logic               drive_en_o,
  output logic               goal_reached_o
);

  logic [31:0] dgp_q, dgi_q, bgp_q, bgi_q, sgp_q, sgi_q;
  logic [8:0]  ads_q;
  logic [14:0] aan_q;
  logic signed [15:0] tx_q, ty_q, th_q;
  logic rot_q, reached_q;
  logic signed [31:0] dsum_q, bsum_q, ssum_q;

  // per-tick working registers
  logic [1:0]  op_q;
  logic signed [15:0] hd_q;
  logic signed [16:0] dx_q, dy_q;
  logic signed [17:0] terr_q;
  logic [33:0] rem_q;
  logic [33:0] root_q;
  logic [4:0]  sq_i_q;
  logic signed [34:0] cx_q, cy_q;
  logic signed [17:0] ang_q;
  logic [3:0]  ci_q;
  logic signed [9:0]  dist_q;
  logic signed [17:0] cap_q;
  logic signed [33:0] acc_q;  // accumulates d or h
  logic signed [31:0] d_q, h_q;
  logic signed [33:0] l_q, r_q;
  logic [32:0] big_q, num_q;
  logic [14:0] quo_q;
  logic [3:0]  qi_q;
  logic lsmall_q;            // the smaller-magnitude side is left
  logic signed [15:0] lo_q, ro_q;
  logic on_q, rch_out_q;

  function automatic logic signed [17:0] wrap18(input logic signed [17:0] a);
    logic signed [17:0] r;
    r = a;
    if (r > 18'sd25736) r = r - 18'sd51472;
    else if (r <= -18'sd25736) r = r + 18'sd51472;
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) r = 32'sh7fffffff;
    else if (v < -34'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [32:0] abs34(input logic signed [33:0] v);
    logic signed [33:0] a;
    a = v[33] ? -v : v;
    return a[32:0];
  endfunction

  // multiplier operand selection per product step
  logic [31:0] m_gain;
  logic signed [31:0] m_val;
  logic [4:0]  m_sh;
  always_comb begin
    m_gain = dgp_q; m_val = 32'(dist_q); m_sh = 5'd10;
    unique case ({rot_q, step_i[0]})
      2'b00: begin m_gain = step_i[1] ? bgp_q : dgp_q;
                   m_val = step_i[1] ? 32'(cap_q) : 32'(dist_q);
                   m_sh = step_i[1] ? 5'd23 : 5'd10; end
      2'b01: begin m_gain = step_i[1] ? bgi_q : dgi_q;
                   m_val = step_i[1] ? bsum_q : dsum_q;
                   m_sh = step_i[1] ? 5'd23 : 5'd10; end
      2'b10: begin m_gain = sgp_q; m_val = 32'(terr_q); m_sh = 5'd23; end
      2'b11: begin m_gain = sgi_q; m_val = ssum_q; m_sh = 5'd23; end
      default: ;
    endcase
  end
  logic [31:0] m_abs;
  logic [63:0] m_prod, m_shd;
  logic signed [33:0] m_term;
  assign m_abs  = m_val[31] ? 32'(-m_val) : m_val;
  assign m_prod = {32'd0, m_gain} * {32'd0, m_abs};
  assign m_shd  = m_prod >> m_sh;
  // proportional terms stay below 2^31, so clipping the other term at 2^32-1
  // still saturates the same way and keeps the 34-bit sum from overflowing
  logic [63:0] m_clip;
  assign m_clip = (m_shd > 64'h0_ffff_ffff) ? 64'h0_ffff_ffff : m_shd;
  assign m_term = m_val[31] ? -$signed({1'b0, m_clip[32:0]}) : $signed({1'b0, m_clip[32:0]});

  logic [33:0] sq_bit, sq_try;
  assign sq_bit = 34'd1 << {sq_i_q, 1'b0};
  assign sq_try = root_q + sq_bit;

  logic signed [34:0] cxs, cys;
  assign cxs = cx_q >>> ci_q;
  assign cys = cy_q >>> ci_q;

  logic [33:0] dv_trial;
  logic        dv_bit;
  logic [14:0] q_last;
  assign dv_trial = {num_q[32:0], 1'b0};
  assign dv_bit   = dv_trial >= {1'b0, big_q};
  assign q_last   = {quo_q[13:0], dv_bit};

  logic signed [16:0] ndx, ndy;
  logic [15:0] adx, ady;
  logic [33:0] sq_sum;
  logic signed [17:0] terr_n;
  assign ndx = 17'(tx_q) - 17'(pos_x_i);
  assign ndy = 17'(ty_q) - 17'(pos_y_i);
  assign adx = ndx[16] ? 16'(-ndx) : ndx[15:0];
  assign ady = ndy[16] ? 16'(-ndy) : ndy[15:0];
  assign sq_sum = 34'({16'd0, adx} * {16'd0, adx}) + 34'({16'd0, ady} * {16'd0, ady});
  assign terr_n = wrap18(18'(heading_i) - 18'(th_q));

  logic [8:0] dcl;
  logic signed [17:0] cap0;
  always_comb begin
    dcl = (root_q > 34'd300) ? 9'd300 : root_q[8:0];
    cap0 = wrap18(18'(hd_q) - ang_q);
  end

  logic signed [33:0] lsum, rsum;
  assign lsum = rot_q ? 34'(h_q) : 34'(d_q) + 34'(h_q);
  assign rsum = rot_q ? -34'(h_q) : 34'(d_q) - 34'(h_q);

  assign sts_o.rot = rot_q;
  assign sts_o.need_div = (abs34(lsum) > abs34(rsum)) ? (abs34(lsum) > 33'd16384)
                                                      : (abs34(rsum) > 33'd16384);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dgp_q <= 32'd109052; dgi_q <= 32'd923;
      bgp_q <= 32'd251658240; bgi_q <= 32'd0;
      sgp_q <= 32'd251658240; sgi_q <= 32'd0;
      ads_q <= 9'd10; aan_q <= 15'd410;
      tx_q <= '0; ty_q <= '0; th_q <= '0;
      rot_q <= 1'b0; reached_q <= 1'b1;
      dsum_q <= '0; bsum_q <= '0; ssum_q <= '0;
      lo_q <= '0; ro_q <= '0; on_q <= 1'b0; rch_out_q <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_DGP: dgp_q <= cfg_data_i;
          REG_DGI: dgi_q <= cfg_data_i;
          REG_BGP: bgp_q <= cfg_data_i;
          REG_BGI: bgi_q <= cfg_data_i;
          REG_SGP: sgp_q <= cfg_data_i;
          REG_SGI: sgi_q <= cfg_data_i;
          REG_ADS: ads_q <= cfg_data_i[8:0];
          REG_AAN: aan_q <= cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (cmd_i.load && (opcode_i == OP_LINE || opcode_i == OP_ROT)) begin
        rot_q <= (opcode_i == OP_ROT);
        if (opcode_i == OP_LINE) begin
          tx_q <= goal_x_i; ty_q <= goal_y_i; th_q <= heading_i;
        end else begin
          tx_q <= pos_x_i; ty_q <= pos_y_i; th_q <= goal_heading_i;
        end
        reached_q <= 1'b0;
        dsum_q <= '0; bsum_q <= '0; ssum_q <= '0;
      end
      if (cmd_i.post) begin
        if (rot_q) begin
          ssum_q <= sat32(34'(ssum_q) + 34'(terr_q));
          if (dcl > 9'd100) dsum_q <= '0;
          if ($unsigned(terr_q[17] ? -terr_q : terr_q) < 18'(aan_q)) reached_q <= 1'b1;
        end else begin
          dsum_q <= sat32(((dcl > 9'd100) ? 34'sd0 : 34'(dsum_q)) +
                          ((cap0 < -18'sd12868 || cap0 > 18'sd12868) ? -34'(dcl) : 34'(dcl)));
          bsum_q <= sat32(34'(bsum_q) + 34'(cap0 < -18'sd12868 ? cap0 + 18'sd25736 :
                          cap0 > 18'sd12868 ? cap0 - 18'sd25736 : cap0));
          if (dcl < ads_q && $unsigned(cap0[17] ? -cap0 : cap0) < 18'(aan_q)
              && cap0 >= -18'sd12868 && cap0 <= 18'sd12868)
            reached_q <= 1'b1;
          else if (dcl < ads_q && (cap0 < -18'sd12868 || cap0 > 18'sd12868)) begin
            // folded bearing is |cap|-pi in magnitude
            if ($unsigned(cap0[17] ? 18'sd25736 + cap0 : 18'sd25736 - cap0) < 18'(aan_q))
              reached_q <= 1'b1;
          end
        end
      end
      if (cmd_i.finish) begin
        if (op_q == OP_TICK) begin
          on_q <= !reached_q;
          lo_q <= reached_q ? 16'sd0 : lo_q;
          ro_q <= reached_q ? 16'sd0 : ro_q;
          rch_out_q <= reached_q;
        end else begin
          on_q <= 1'b0; lo_q <= '0; ro_q <= '0;
          rch_out_q <= reached_q;
        end
      end else if (cmd_i.combine) begin
        // unscaled commands are within range only if no division follows
        lo_q <= lsum[15:0]; ro_q <= rsum[15:0];
      end else if (cmd_i.div_st && qi_q == 4'd0) begin
        // last quotient bit is formed in this same step
        if (lsmall_q) begin
          lo_q <= l_q[33] ? -$signed({1'b0, q_last}) : $signed({1'b0, q_last});
          ro_q <= r_q[33] ? -16'sd16384 : 16'sd16384;
        end else begin
          ro_q <= r_q[33] ? -$signed({1'b0, q_last}) : $signed({1'b0, q_last});
          lo_q <= l_q[33] ? -16'sd16384 : 16'sd16384;
        end
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= opcode_i; hd_q <= heading_i;
      dx_q <= ndx; dy_q <= ndy; terr_q <= terr_n;
      rem_q <= sq_sum; root_q <= '0; sq_i_q <= 5'd16;
      ci_q <= '0;
      if (ndx == 0 && ndy == 0) begin
        cx_q <= '0; cy_q <= '0; ang_q <= '0;
      end else if (ndx < 0) begin
        if (ndy >= 0) begin
          cx_q <= 35'(ndy) <<< 16; cy_q <= -(35'(ndx) <<< 16); ang_q <= 18'sd12868;
        end else begin
          cx_q <= -(35'(ndy) <<< 16); cy_q <= 35'(ndx) <<< 16; ang_q <= -18'sd12868;
        end
      end else begin
        cx_q <= 35'(ndx) <<< 16; cy_q <= 35'(ndy) <<< 16; ang_q <= '0;
      end
      acc_q <= '0;
    end
    if (cmd_i.sqrt_st) begin
      if (rem_q >= sq_try) begin
        rem_q <= rem_q - sq_try;
        root_q <= (root_q >> 1) + sq_bit;
      end else begin
        root_q <= root_q >> 1;
      end
      sq_i_q <= sq_i_q - 5'd1;
    end
    if (cmd_i.cord_st && !(dx_q == 0 && dy_q == 0)) begin
      if (cy_q > 0) begin
        cx_q <= cx_q + cys; cy_q <= cy_q - cxs; ang_q <= ang_q + 18'(atan_entry(ci_q));
      end else begin
        cx_q <= cx_q - cys; cy_q <= cy_q + cxs; ang_q <= ang_q - 18'(atan_entry(ci_q));
      end
      ci_q <= ci_q + 4'd1;
    end
    if (cmd_i.post) begin
      if (rot_q) begin
        dist_q <= 10'(dcl);
        cap_q <= cap0;
      end else if (cap0 < -18'sd12868) begin
        dist_q <= -10'(dcl); cap_q <= cap0 + 18'sd25736;
      end else if (cap0 > 18'sd12868) begin
        dist_q <= -10'(dcl); cap_q <= cap0 - 18'sd25736;
      end else begin
        dist_q <= 10'(dcl); cap_q <= cap0;
      end
    end
    if (cmd_i.mul_st) begin
      if (step_i[0]) begin
        if (rot_q || step_i[1]) h_q <= sat32(acc_q + m_term);
        else d_q <= sat32(acc_q + m_term);
        acc_q <= '0;
      end else begin
        acc_q <= m_term;
      end
      if (rot_q) d_q <= '0;
    end
    if (cmd_i.combine) begin
      l_q <= lsum; r_q <= rsum;
      lsmall_q <= !(abs34(lsum) > abs34(rsum));
      big_q <= (abs34(lsum) > abs34(rsum)) ? abs34(lsum) : abs34(rsum);
      num_q <= (abs34(lsum) > abs34(rsum)) ? abs34(rsum) : abs34(lsum);
      quo_q <= '0; qi_q <= 4'd14;
    end
    if (cmd_i.div_st) begin
      // restoring division of (small*2^14)/big, small <= big, 15 quotient bits
      if (qi_q == 4'd14) begin
        if ({1'b0, num_q} >= {1'b0, big_q}) begin
          num_q <= num_q - big_q; quo_q <= 15'd1;
        end else quo_q <= 15'd0;
      end else begin
        if (dv_trial >= {1'b0, big_q}) begin
          num_q <= 33'(dv_trial - {1'b0, big_q}); quo_q <= {quo_q[13:0], 1'b1};
        end else begin
          num_q <= dv_trial[32:0]; quo_q <= {quo_q[13:0], 1'b0};
        end
      end
      if (qi_q != 4'd0) qi_q <= qi_q - 4'd1;
    end
  end

  assign left_cmd_o = lo_q;
  assign right_cmd_o = ro_q;
  assign drive_en_o = on_q;
  assign goal_reached_o = rch_out_q;

endmodule

// ===== src/ppdc_ctrl.sv =====
// ppdc_ctrl: sequencer for one item and the output handshake
// depends on ppdc_pkg; drives ppdc_datapath by command
module ppdc_ctrl
  import ppdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  ppdc_sts_t   sts_i,
  output ppdc_cmd_t   cmd_o,
  output logic [2:0]  step_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQRT = 3'd1;
  localparam logic [2:0] S_CORD = 3'd2;
  localparam logic [2:0] S_POST = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_COMB = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       ov_q, ov_d;
  logic       busy;

  // one item in flight; the output register decouples the receiver
  assign busy = (state_q != S_IDLE) || (ov_q && out_stall_i);
  assign in_stall_o = busy;
  assign out_valid_o = ov_q;
  assign step_o = cnt_q[2:0];

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; ov_d = ov_q;
    cmd_o = '0;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    unique case (state_q)
      S_IDLE: if (in_valid_i && !busy) begin
        cmd_o.load = 1'b1; cnt_d = '0;
        state_d = (opcode_i == OP_TICK) ? S_SQRT : S_FIN;
      end
      S_SQRT: begin
        cmd_o.sqrt_st = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd16) begin state_d = S_CORD; cnt_d = '0; end
      end
      S_CORD: begin
        cmd_o.cord_st = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd13) begin state_d = S_POST; cnt_d = '0; end
      end
      S_POST: begin cmd_o.post = 1'b1; state_d = S_MUL; cnt_d = '0; end
      S_MUL: begin
        cmd_o.mul_st = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == (sts_i.rot ? 5'd1 : 5'd3)) begin state_d = S_COMB; cnt_d = '0; end
      end
      S_COMB: begin
        cmd_o.combine = 1'b1;
        state_d = sts_i.need_div ? S_DIV : S_FIN;
      end
      S_DIV: begin
        cmd_o.div_st = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd14) state_d = S_FIN;
      end
      S_FIN: begin cmd_o.finish = 1'b1; ov_d = 1'b1; state_d = S_IDLE; end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; ov_q <= ov_d;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("request taken while busy");
  a_fin_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |=> out_valid_o) else $error("result not presented");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o)) else $error("more than one datapath command");

endmodule

// ===== src/polar_pi_drive_controller_unit.sv =====
// polar pi drive controller: two-wheel goal steering with polar pi control
// usage: one request on the in channel gives exactly one result on the out channel.
// opcode tick carries the pose; line goal and rotation goal load a new target.
// a request is taken when in_valid_i is high and in_stall_o low; a result leaves when
// out_valid_o is high and out_stall_i low. configuration writes use cfg_valid_i and
// cfg_ready_o with cfg_index_i and cfg_data_i, only while the block is idle; the user must
// keep to this, the block does not enforce it. a request other than a tick goes from load
// to finish; a tick runs the 17-step square root, 14-step cordic, 2 or 4 multiplier passes
// on the single 32x32 multiplier and, when a command exceeds one, a 15-step divider.
// one request is processed at a time; the next is taken once the result register
// is free, so a stalled receiver holds the block with its result kept stable.
// reset loads the default gains and thresholds, clears the target and integrators,
// selects line mode and sets the reached flag.
module polar_pi_drive_controller_unit
  import ppdc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] heading_i,
  input  logic signed [15:0] goal_x_i,
  input  logic signed [15:0] goal_y_i,
  input  logic signed [15:0] goal_heading_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] left_cmd_o,
  output logic signed [15:0] right_cmd_o,
  output logic               drive_en_o,
  output logic               goal_reached_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  ppdc_cmd_t  cmd;
  ppdc_sts_t  sts;
  logic [2:0] step;

  assign cfg_ready_o = 1'b1;

  ppdc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .opcode_i,
    .out_valid_o, .out_stall_i, .sts_i(sts), .cmd_o(cmd), .step_o(step)
  );

  ppdc_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .step_i(step), .sts_o(sts),
    .opcode_i, .pos_x_i, .pos_y_i, .heading_i, .goal_x_i, .goal_y_i, .goal_heading_i,
    .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i), .cfg_data_i,
    .left_cmd_o, .right_cmd_o, .drive_en_o, .goal_reached_o
  );

endmodule
